@@ rtl/jlmp_pkg.sv @@
`timescale 1ns / 1ps

package jlmp_pkg;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RISE  = 3'd1;
  localparam logic [2:0] PH_FALL  = 3'd2;
  localparam logic [2:0] PH_DRISE = 3'd3;
  localparam logic [2:0] PH_DFALL = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  localparam logic [1:0] CFG_ACCEL_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_JERK_RATE     = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP     = 2'd2;
  localparam logic [1:0] CFG_STOP_VELOCITY = 2'd3;

  localparam logic [30:0] ACCEL_LIMIT_RST   = 31'd65536;
  localparam logic [30:0] JERK_RATE_RST     = 31'd65536;
  localparam logic [15:0] TIME_STEP_RST     = 16'd655;
  localparam logic [30:0] STOP_VELOCITY_RST = 31'd131072;

  localparam logic [1:0] MS_JERK = 2'd0;
  localparam logic [1:0] MS_ACC  = 2'd1;
  localparam logic [1:0] MS_VEL  = 2'd2;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] accel_now;
    logic [2:0]         phase;
  } out_item_t;

  typedef struct packed {
    logic [30:0] accel_limit;
    logic [30:0] jerk_rate;
    logic [15:0] time_step;
    logic [30:0] stop_velocity;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_upd;
    logic       vel_upd;
    logic       pos_upd;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
  } dp_stat_t;

endpackage

@@ rtl/jerk_limited_motion_profile.sv @@
`timescale 1ns / 1ps

// Jerk-limited S-curve motion profile generator.
// Input channel (in_valid/in_ready, in_data): mode 1 starts a move (enters the
// rising-acceleration phase, no result); mode 0 is a control-period tick that
// produces one result transaction.
// Output channel (out_valid/out_ready, out_data): position, speed, accel_now
// and phase after the tick, Q16.16.
// Config port: cfg_we with cfg_index/cfg_data writes a register;
// write only while no tick is in flight.
// A tick in a moving phase passes the states JD, ACC, MV, VEL, MP, POS and
// EMIT before out_valid rises; one shared 32x17 multiplier is used three
// times in series (jerk*dt, accel*dt, velocity*dt), each product registered.
// An idle tick goes from acceptance straight to EMIT. A new transaction is
// taken only in idle, after the previous tick is emitted; a start stays idle.
// The block accepts a new transaction while a result waits; a finished tick
// holds in the emit stage while the receiver stalls with a result pending.
// Reset (rst, synchronous) clears state to idle with zero motion and loads
// the default configuration.
module jerk_limited_motion_profile (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jlmp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jlmp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import jlmp_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  jlmp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jlmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  jlmp_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

@@ rtl/jlmp_cfg.sv @@
`timescale 1ns / 1ps

module jlmp_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data,
  output jlmp_pkg::cfg_t    cfg
);
  import jlmp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_limit   <= ACCEL_LIMIT_RST;
      cfg.jerk_rate     <= JERK_RATE_RST;
      cfg.time_step     <= TIME_STEP_RST;
      cfg.stop_velocity <= STOP_VELOCITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_LIMIT:   cfg.accel_limit   <= cfg_data;
        CFG_JERK_RATE:     cfg.jerk_rate     <= cfg_data;
        CFG_TIME_STEP:     cfg.time_step     <= cfg_data[15:0];
        CFG_STOP_VELOCITY: cfg.stop_velocity <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/jlmp_dp.sv @@
`timescale 1ns / 1ps

module jlmp_dp (
  input  logic                clk,
  input  logic                rst,
  input  jlmp_pkg::cfg_t      cfg,
  input  jlmp_pkg::dp_cmd_t   cmd,
  output jlmp_pkg::dp_stat_t  stat,
  output jlmp_pkg::out_item_t out_data
);
  import jlmp_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic [2:0]         phase;
  logic [2:0]         phase_next;
  logic signed [31:0] accel;
  logic signed [31:0] accel_next;
  logic signed [31:0] velocity;
  logic signed [31:0] velocity_next;
  logic signed [31:0] position;
  logic signed [48:0] prod;

  logic signed [31:0] mul_op;
  logic signed [48:0] prod_full;
  logic signed [32:0] scaled;
  logic               sub;
  logic signed [33:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic signed [32:0] acc33;
  logic signed [32:0] ma33;
  logic signed [32:0] stop33;
  logic signed [33:0] vel_sum;
  logic signed [33:0] pos_sum;

  always_comb begin
    case (cmd.mul_sel)
      MS_JERK: mul_op = $signed({1'b0, cfg.jerk_rate});
      MS_ACC:  mul_op = accel;
      MS_VEL:  mul_op = velocity;
      default: mul_op = '0;
    endcase
  end

  assign prod_full = 49'(mul_op) * 49'($signed({33'd0, cfg.time_step}));
  // arithmetic >>16 of the exact product is a floor
  assign scaled = prod[48:16];

  assign sub     = (phase == PH_FALL) || (phase == PH_DRISE);
  assign acc_sum = sub ? 34'(accel) - 34'(scaled) : 34'(accel) + 34'(scaled);
  assign acc_sat = sat32(acc_sum);
  assign acc33   = 33'(acc_sat);
  assign ma33    = $signed({2'b00, cfg.accel_limit});
  assign stop33  = $signed({2'b00, cfg.stop_velocity});
  assign vel_sum = 34'(velocity) + 34'(scaled);
  assign pos_sum = 34'(position) + 34'(scaled);

  always_comb begin
    phase_next    = phase;
    accel_next    = accel;
    velocity_next = velocity;
    case (phase)
      PH_RISE: begin
        accel_next = acc_sat;
        if (acc33 >= ma33) phase_next = PH_FALL;
      end
      PH_FALL: begin
        if (acc_sat <= 0) begin
          accel_next = '0;
          phase_next = PH_DRISE;
        end else begin
          accel_next = acc_sat;
        end
      end
      PH_DRISE: begin
        accel_next = acc_sat;
        if (acc33 <= -ma33) phase_next = PH_DFALL;
      end
      PH_DFALL: begin
        if (acc_sat >= 0 || 33'(velocity) <= stop33) begin
          accel_next    = '0;
          velocity_next = '0;
          phase_next    = PH_DONE;
        end else begin
          accel_next = acc_sat;
        end
      end
      PH_DONE: phase_next = PH_IDLE;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      accel    <= '0;
      velocity <= '0;
      position <= '0;
    end else begin
      if (cmd.start) begin
        phase <= PH_RISE;
      end else if (cmd.acc_upd) begin
        phase    <= phase_next;
        accel    <= accel_next;
        velocity <= velocity_next;
      end
      if (cmd.vel_upd) velocity <= sat32(vel_sum);
      if (cmd.pos_upd) position <= sat32(pos_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= prod_full;
    if (cmd.emit) begin
      out_data.position  <= position;
      out_data.speed     <= velocity;
      out_data.accel_now <= accel;
      out_data.phase     <= phase;
    end
  end

  assign stat.active = phase inside {[PH_RISE:PH_DONE]};

endmodule

@@ rtl/jlmp_ctrl.sv @@
`timescale 1ns / 1ps

module jlmp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  output logic               out_valid,
  input  logic               out_ready,
  input  jlmp_pkg::dp_stat_t stat,
  output jlmp_pkg::dp_cmd_t  cmd
);
  import jlmp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_JD   = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_MV   = 3'd3;
  localparam logic [2:0] ST_VEL  = 3'd4;
  localparam logic [2:0] ST_MP   = 3'd5;
  localparam logic [2:0] ST_POS  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;
  logic       emit;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !in_mode) state_next = stat.active ? ST_JD : ST_EMIT;
      end
      ST_JD:   state_next = ST_ACC;
      ST_ACC:  state_next = ST_MV;
      ST_MV:   state_next = ST_VEL;
      ST_VEL:  state_next = ST_MP;
      ST_MP:   state_next = ST_POS;
      ST_POS:  state_next = ST_EMIT;
      ST_EMIT: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.start   = accept && in_mode;
    cmd.mul_en  = (state == ST_JD) || (state == ST_MV) || (state == ST_MP);
    cmd.mul_sel = (state == ST_MV) ? MS_ACC : ((state == ST_MP) ? MS_VEL : MS_JERK);
    cmd.acc_upd = (state == ST_ACC);
    cmd.vel_upd = (state == ST_VEL);
    cmd.pos_upd = (state == ST_POS);
    cmd.emit    = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_hold_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_valid && !out_ready) |=> (state == ST_EMIT))
    else $error("result emitted over a stalled transaction");

  a_rose_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("out_valid raised outside emit");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_mode && !stat.active) |=> (state == ST_EMIT))
    else $error("idle tick did not go straight to emit");

  a_start_stays: assert property (@(posedge clk) disable iff (rst)
    (accept && in_mode) |=> (state == ST_IDLE))
    else $error("start transaction left idle");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import jlmp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int TARGET_ITEMS = 950;
  localparam int SETTLE_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_ACCEL_LIMIT;
  logic [30:0] cfg_data = '0;

  jerk_limited_motion_profile u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Profile state and register copies
  logic [30:0] lim_accel = ACCEL_LIMIT_RST;
  logic [30:0] jerk_mag  = JERK_RATE_RST;
  logic [15:0] step_dt   = TIME_STEP_RST;
  logic [30:0] stop_vel  = STOP_VELOCITY_RST;
  logic [2:0]  ph        = PH_IDLE;
  int          acc_q16   = 0;
  int          vel_q16   = 0;
  int          pos_q16   = 0;
  int          tgt_q16   = 0;

  in_item_t  motion_pend[$];
  out_item_t expected_motion[$];

  int send_idle_pct = 23;
  int recv_idle_pct = 62;
  int items_queued  = 0;
  int err_count     = 0;
  int cycles        = 0;
  bit in_taken      = 1'b0;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // floor(x * dt / 2^16)
  function automatic longint scale_dt(longint x);
    return (x * longint'(step_dt)) >>> 16;
  endfunction

  function automatic void advance_motion(in_item_t it);
    longint jd;
    longint ma;
    if (it.mode) begin
      tgt_q16 = it.target_position;
      ph = PH_RISE;
      return;
    end
    if (ph >= PH_RISE && ph <= PH_DONE) begin
      jd = scale_dt(longint'(jerk_mag));
      ma = longint'(lim_accel);
      case (ph)
        PH_RISE: begin
          acc_q16 = sat32(longint'(acc_q16) + jd);
          if (longint'(acc_q16) >= ma) ph = PH_FALL;
        end
        PH_FALL: begin
          acc_q16 = sat32(longint'(acc_q16) - jd);
          if (acc_q16 <= 0) begin
            acc_q16 = 0;
            ph = PH_DRISE;
          end
        end
        PH_DRISE: begin
          acc_q16 = sat32(longint'(acc_q16) - jd);
          if (longint'(acc_q16) <= -ma) ph = PH_DFALL;
        end
        PH_DFALL: begin
          acc_q16 = sat32(longint'(acc_q16) + jd);
          if (acc_q16 >= 0 || longint'(vel_q16) <= longint'(stop_vel)) begin
            vel_q16 = 0;
            acc_q16 = 0;
            ph = PH_DONE;
          end
        end
        default: ph = PH_IDLE;
      endcase
      vel_q16 = sat32(longint'(vel_q16) + scale_dt(longint'(acc_q16)));
      pos_q16 = sat32(longint'(pos_q16) + scale_dt(longint'(vel_q16)));
    end
    expected_motion.push_back('{position: pos_q16, speed: vel_q16,
                                accel_now: acc_q16, phase: ph});
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (motion_pend.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= motion_pend.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: outputs sampled on the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_motion.size() == 0) begin
          err_count++;
          $display("%0t ns: unexpected transaction pos %h speed %h accel %h phase %0d",
                   $time, out_data.position, out_data.speed, out_data.accel_now,
                   out_data.phase);
        end else begin
          want = expected_motion.pop_front();
          if (out_data !== want) begin
            err_count++;
            $display("%0t ns: mismatch expected pos %h speed %h accel %h phase %0d,",
                     $time, want.position, want.speed, want.accel_now, want.phase,
                     " actual pos %h speed %h accel %h phase %0d",
                     out_data.position, out_data.speed, out_data.accel_now,
                     out_data.phase);
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_motion(in_data);
        in_taken = 1'b1;
      end
    end
  end

  task automatic push_item(input logic mode, input logic [31:0] tgt);
    motion_pend.push_back('{mode: mode, target_position: tgt});
    items_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ACCEL_LIMIT:   lim_accel = val;
      CFG_JERK_RATE:     jerk_mag  = val;
      CFG_TIME_STEP:     step_dt   = val[15:0];
      CFG_STOP_VELOCITY: stop_vel  = val;
      default: begin
      end
    endcase
  endtask

  task automatic program_profile(input logic [30:0] ma, input logic [30:0] jr,
                                 input logic [15:0] dt, input logic [30:0] sv);
    write_reg(CFG_ACCEL_LIMIT, ma);
    write_reg(CFG_JERK_RATE, jr);
    write_reg(CFG_TIME_STEP, {15'd0, dt});
    write_reg(CFG_STOP_VELOCITY, sv);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // input side is checked on the rising edge, result queue on the falling edge
  task automatic wait_drained;
    bit in_clear;
    do begin
      @(posedge clk);
      in_clear = (motion_pend.size() == 0) && !in_valid;
      @(negedge clk);
    end while (!(in_clear && expected_motion.size() == 0));
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          steps;
    int          n;
    int          batch;
    int          sel;
    logic [30:0] ma;
    logic [30:0] jr;
    logic [30:0] sv;
    logic [15:0] dt;
    longint      jl;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // default registers, restart while moving
    push_item(1'b1, 32'h7fffffff);
    push_item(1'b0, '0);
    push_item(1'b1, 32'h80000000);
    push_item(1'b0, '0);
    wait_drained();

    // one tick per phase, then done and idle ticks
    program_profile(31'h30000, 31'h100000, 16'h4000, 31'd131072);
    push_item(1'b1, 32'h00010000);
    repeat (6) push_item(1'b0, 32'hffffffff);
    wait_drained();

    // all registers at maximum: saturation everywhere
    program_profile(31'h7fffffff, 31'h7fffffff, 16'hffff, 31'h7fffffff);
    push_item(1'b1, 32'h55555555);
    repeat (8) push_item(1'b0, 32'haaaaaaaa);
    wait_drained();

    // zero limits
    program_profile('0, '0, 16'hffff, '0);
    push_item(1'b1, '0);
    repeat (5) push_item(1'b0, '0);
    wait_drained();

    // zero time step: profile frozen
    program_profile(31'h30000, 31'h100000, 16'h0000, 31'd131072);
    push_item(1'b1, 32'h12345678);
    repeat (2) push_item(1'b0, '0);
    wait_drained();

    while (items_queued < TARGET_ITEMS) begin
      if (items_queued < TARGET_ITEMS / 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 62;
      end else if (items_queued < 2 * TARGET_ITEMS / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      sel = $urandom_range(9);
      if (sel == 0) dt = 16'd1;
      else if (sel == 1) dt = 16'hffff;
      else dt = 16'($urandom_range(64, 65535));
      if (sel == 2) begin
        ma = 31'($urandom);
        jr = 31'($urandom);
        dt = 16'($urandom);
        steps = 8;
      end else begin
        ma = 31'($urandom_range(1 << 10, 1 << 24));
        steps = $urandom_range(1, 8);
        jl = ((longint'(ma / steps) << 16) + dt - 1) / dt;
        jr = (jl > 64'sh7fffffff) ? 31'h7fffffff : jl[30:0];
      end
      case ($urandom_range(3))
        0: sv = '0;
        1: sv = 31'($urandom_range(0, 1 << 20));
        2: sv = 31'($urandom);
        default: sv = 31'($urandom_range(0, ma));
      endcase
      program_profile(ma, jr, dt, sv);

      batch = 0;
      while (batch < 60) begin
        push_item(1'b1, $urandom);
        n = $urandom_range(3, 4 * steps + 10);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(29) == 0) push_item(1'b1, $urandom);
          else push_item(1'b0, $urandom);
        end
        batch += n + 1;
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 3)) push_item(1'($urandom_range(1)), $urandom);
          batch += 2;
        end
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
